### rtl/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared widths, operation and status codes, and controller command/status
// types for the binary max-heap queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;
	localparam int DEF_CAPACITY = 64;
	localparam int KEY_W = 32;
	localparam int CNT_OUT_W = 7;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE_MAX = 2'd1;
	localparam logic [1:0] OP_REMOVE_VAL = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// Datapath micro-operations issued by the controller.
	localparam logic [3:0] DP_NOP = 4'd0;
	localparam logic [3:0] DP_LOAD = 4'd1;     // latch op/key, clear result fields
	localparam logic [3:0] DP_APPEND = 4'd2;   // write key at count, count++, pos=count
	localparam logic [3:0] DP_RD_POS = 4'd3;   // read slot pos
	localparam logic [3:0] DP_RD_PAR = 4'd4;   // capture cur, read parent
	localparam logic [3:0] DP_UP_CMP = 4'd5;   // not decoded by the datapath (no action)
	localparam logic [3:0] DP_WR_A = 4'd6;     // swap write 1 (pos <- other)
	localparam logic [3:0] DP_WR_B = 4'd7;     // swap write 2 (other <- cur), pos=other
	localparam logic [3:0] DP_RD_L = 4'd8;     // capture cur, read left child
	localparam logic [3:0] DP_RD_R = 4'd9;     // capture left, read right child
	localparam logic [3:0] DP_DN_CMP = 4'd10;  // pick larger child: other=its index, rd=its value
	localparam logic [3:0] DP_RM_LAST = 4'd11; // count--, read last slot
	localparam logic [3:0] DP_FILL = 4'd12;    // write last into pos (if pos<count)
	localparam logic [3:0] DP_SCAN_RD = 4'd13; // read slot scan index
	localparam logic [3:0] DP_SCAN_NX = 4'd14; // advance scan index
	localparam logic [3:0] DP_SET_POS0 = 4'd15;// pos=0 and set top/removed

	typedef struct packed {
		logic [3:0] cmd;
		logic       scan_clr;
		logic       save_hole;
		logic       pos_from_hole;
		logic       cnt_removed;
		logic [1:0] status;
		logic       set_status;
	} bmhq_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       full;
		logic       empty;
		logic       pos_zero;
		logic       up_swap;
		logic       dn_swap;
		logic       scan_done;
		logic       scan_hit;
		logic       pos_in;
	} bmhq_stat_t;
endpackage

### rtl/bmhq_datapath.sv
// ----------------------------------------------------------------------------
// bmhq_datapath
// Heap store memory, count, position and compare registers.
// ----------------------------------------------------------------------------
module bmhq_datapath
	import bmhq_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY,
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bmhq_cmd_t                   cmd,
	output bmhq_stat_t                  stat,
	input  logic [1:0]                  op,
	input  logic signed [KEY_W-1:0]     key_value,
	output logic [1:0]                  status,
	output logic signed [KEY_W-1:0]     top_removed,
	output logic [CNT_OUT_W-1:0]        removed_count,
	output logic [CNT_OUT_W-1:0]        occupancy
);
	logic signed [KEY_W-1:0] mem_q [CAPACITY];
	logic signed [KEY_W-1:0] rd_q, cur_q, left_q, key_q;
	logic [CW-1:0] count_q, pos_q, other_q, scan_q, hole_q;
	logic [1:0] op_q;
	logic [CW:0] left_i, right_i;
	logic [CW-1:0] parent_i;
	logic [CW-1:0] rd_addr;
	logic rd_en, wr_en;
	logic [CW-1:0] wr_addr;
	logic signed [KEY_W-1:0] wr_data;
	logic has_l, has_r;
	logic dn_l, dn_r;

	assign left_i = {pos_q, 1'b1};
	assign right_i = {pos_q, 1'b0} + (CW+1)'(2);
	assign parent_i = (pos_q - CW'(1)) >> 1;
	assign has_l = left_i < {1'b0, count_q};
	assign has_r = right_i < {1'b0, count_q};

	// The right child wins only when strictly larger than both others.
	assign dn_r = has_r && rd_q > cur_q && (!has_l || rd_q > left_q);
	assign dn_l = has_l && left_q > cur_q && !dn_r;

	// The read register loads on read commands, and on the down compare when the
	// left child wins, so a fetched word is held for the compare cycles that follow.
	always_comb begin
		rd_en = 1'b0;
		rd_addr = pos_q;
		wr_en = 1'b0;
		wr_addr = pos_q;
		wr_data = cur_q;
		unique case (cmd.cmd)
			DP_RD_POS: rd_en = 1'b1;
			DP_RD_PAR: begin
				rd_en = 1'b1; rd_addr = parent_i;
			end
			DP_RD_L: begin
				rd_en = 1'b1; rd_addr = left_i[CW-1:0];
			end
			DP_RD_R: begin
				rd_en = 1'b1; rd_addr = right_i[CW-1:0];
			end
			DP_RM_LAST: begin
				rd_en = 1'b1; rd_addr = count_q - CW'(1);
			end
			DP_SCAN_RD: begin
				rd_en = 1'b1; rd_addr = scan_q;
			end
			DP_APPEND: begin
				wr_en = 1'b1; wr_addr = count_q; wr_data = key_q;
			end
			DP_WR_A: begin
				wr_en = 1'b1; wr_addr = pos_q; wr_data = rd_q;
			end
			DP_WR_B: begin
				wr_en = 1'b1; wr_addr = other_q; wr_data = cur_q;
			end
			DP_FILL: begin
				wr_en = pos_q < count_q; wr_addr = pos_q; wr_data = rd_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_q <= mem_q[rd_addr[AW-1:0]];
		else if (cmd.cmd == DP_DN_CMP && dn_l)
			rd_q <= left_q;
		if (wr_en)
			mem_q[wr_addr[AW-1:0]] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			status <= ST_OK;
			removed_count <= '0;
			top_removed <= '0;
		end else begin
			if (cmd.set_status)
				status <= cmd.status;
			if (cmd.cnt_removed)
				removed_count <= removed_count + CNT_OUT_W'(1);
			unique case (cmd.cmd)
				DP_LOAD: begin
					removed_count <= '0;
					top_removed <= '0;
					status <= ST_OK;
				end
				DP_APPEND: count_q <= count_q + CW'(1);
				DP_RM_LAST: count_q <= count_q - CW'(1);
				DP_SET_POS0: top_removed <= rd_q;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_clr)
			scan_q <= '0;
		if (cmd.save_hole)
			hole_q <= scan_q;
		if (cmd.pos_from_hole)
			pos_q <= hole_q;
		unique case (cmd.cmd)
			DP_LOAD: begin
				op_q <= op; key_q <= key_value;
			end
			DP_APPEND: pos_q <= count_q;
			DP_RD_PAR: begin
				cur_q <= rd_q; other_q <= parent_i;
			end
			DP_RD_L: cur_q <= rd_q;
			DP_RD_R: left_q <= rd_q;
			DP_DN_CMP: begin
				if (dn_l)
					other_q <= left_i[CW-1:0];
				else
					other_q <= right_i[CW-1:0];
			end
			DP_WR_B: pos_q <= other_q;
			DP_SCAN_NX: scan_q <= scan_q + CW'(1);
			DP_SET_POS0: pos_q <= '0;
			default: ;
		endcase
	end

	assign stat.op = op_q;
	assign stat.full = count_q >= CW'(CAPACITY);
	assign stat.empty = count_q == '0;
	assign stat.pos_zero = pos_q == '0;
	assign stat.up_swap = cur_q > rd_q;
	assign stat.dn_swap = dn_l || dn_r;
	assign stat.scan_done = scan_q >= count_q;
	assign stat.scan_hit = rd_q == key_q;
	assign stat.pos_in = pos_q < count_q;
	assign occupancy = CNT_OUT_W'(count_q);
endmodule

### rtl/bmhq_ctrl.sv
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Sequencer for insert, remove-max and remove-value operations.
// ----------------------------------------------------------------------------
module bmhq_ctrl
	import bmhq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	output logic       done,
	output bmhq_cmd_t  cmd,
	input  bmhq_stat_t stat
);
	localparam logic [4:0] S_IDLE = 5'd0, S_DISP = 5'd1, S_UP_RD = 5'd2,
		S_UP_PAR = 5'd3, S_UP_CMP = 5'd4, S_UP_WB = 5'd5, S_DN_RD = 5'd6,
		S_DN_L = 5'd7, S_DN_R = 5'd8, S_DN_CMP = 5'd9, S_DN_DEC = 5'd10,
		S_DN_WB = 5'd11, S_RM_TOP = 5'd12, S_RM_LAST = 5'd13, S_RM_FILL = 5'd14,
		S_SC_RD = 5'd15, S_SC_CMP = 5'd16, S_DONE = 5'd17, S_RM_POS = 5'd18,
		S_UP_DEC = 5'd19;

	logic [4:0] state_q, state_d;
	logic rv_q, rv_d; // remove-value in progress: return to scan after sifts

	always_comb begin
		state_d = state_q;
		rv_d = rv_q;
		cmd = '0;
		cmd.cmd = DP_NOP;
		unique case (state_q)
			S_IDLE: if (start) begin
				cmd.cmd = DP_LOAD; state_d = S_DISP; rv_d = 1'b0;
			end
			S_DISP: begin
				priority if (stat.op == OP_INSERT) begin
					if (stat.full) begin
						cmd.set_status = 1'b1; cmd.status = ST_FULL; state_d = S_DONE;
					end else begin
						cmd.cmd = DP_APPEND; state_d = S_UP_RD;
					end
				end else if (stat.op == OP_REMOVE_MAX) begin
					if (stat.empty) begin
						cmd.set_status = 1'b1; cmd.status = ST_EMPTY; state_d = S_DONE;
					end else begin
						cmd.cmd = DP_SET_POS0; state_d = S_RM_TOP;
					end
				end else if (stat.op == OP_REMOVE_VAL) begin
					if (stat.empty) begin
						cmd.set_status = 1'b1; cmd.status = ST_EMPTY; state_d = S_DONE;
					end else begin
						cmd.scan_clr = 1'b1; rv_d = 1'b1; state_d = S_SC_RD;
					end
				end else begin
					state_d = S_DONE;
				end
			end
			// S_DISP set pos to 0; the root read at pos 0 is issued here.
			S_RM_TOP: begin
				cmd.cmd = DP_RD_POS; state_d = S_RM_POS;
			end
			S_RM_POS: begin
				cmd.cmd = DP_SET_POS0; cmd.cnt_removed = 1'b1; state_d = S_RM_LAST;
			end
			S_RM_LAST: begin
				cmd.cmd = DP_RM_LAST; state_d = S_RM_FILL;
			end
			S_RM_FILL: begin
				cmd.cmd = DP_FILL;
				state_d = S_DN_RD;
			end
			S_DN_RD: begin
				if (!stat.pos_in) state_d = rv_q ? S_SC_RD : S_DONE;
				else begin
					cmd.cmd = DP_RD_POS; state_d = S_DN_L;
				end
			end
			S_DN_L: begin
				cmd.cmd = DP_RD_L; state_d = S_DN_R;
			end
			S_DN_R: begin
				cmd.cmd = DP_RD_R; state_d = S_DN_DEC;
			end
			S_DN_DEC: begin
				if (stat.dn_swap) begin
					cmd.cmd = DP_DN_CMP; state_d = S_DN_CMP;
				end else begin
					state_d = S_UP_RD;
				end
			end
			S_DN_CMP: begin
				cmd.cmd = DP_WR_A; state_d = S_DN_WB;
			end
			S_DN_WB: begin
				cmd.cmd = DP_WR_B; state_d = S_DN_RD;
			end
			S_UP_RD: begin
				if (stat.pos_zero || !stat.pos_in) state_d = rv_q ? S_SC_RD : S_DONE;
				else begin
					cmd.cmd = DP_RD_POS; state_d = S_UP_PAR;
				end
			end
			S_UP_PAR: begin
				cmd.cmd = DP_RD_PAR; state_d = S_UP_CMP;
			end
			S_UP_CMP: state_d = S_UP_DEC;
			S_UP_DEC: begin
				if (stat.up_swap) begin
					cmd.cmd = DP_WR_A; state_d = S_UP_WB;
				end else begin
					state_d = rv_q ? S_SC_RD : S_DONE;
				end
			end
			S_UP_WB: begin
				cmd.cmd = DP_WR_B; state_d = S_UP_RD;
			end
			S_SC_RD: begin
				if (stat.scan_done) state_d = S_DONE;
				else begin
					cmd.cmd = DP_SCAN_RD; state_d = S_SC_CMP;
				end
			end
			S_SC_CMP: begin
				if (stat.scan_hit) begin
					cmd.save_hole = 1'b1; cmd.cnt_removed = 1'b1;
					cmd.scan_clr = 1'b1; state_d = S_RM_POS;
				end else begin
					cmd.cmd = DP_SCAN_NX; state_d = S_SC_RD;
				end
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
		// Remove-value reuses the remove path with the hole as position.
		if (state_q == S_RM_POS && rv_q) begin
			cmd.cmd = DP_NOP; cmd.cnt_removed = 1'b0; cmd.pos_from_hole = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rv_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rv_q <= rv_d;
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_DONE;
endmodule

### rtl/binary_max_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_max_heap_queue
// Binary max-heap priority queue with insert, remove-max and remove-value.
// ----------------------------------------------------------------------------
// Insert sifts the new key up one level at a time; remove-max refills the
// root from the last slot and sifts it down, then up, one level at a time.
// Remove-value rescans the store for each match, reading entries in order,
// plus a remove per match. One request at a time; busy is high while it runs.
// The result beat is shown for one cycle on done; the receiver cannot stall.
// Reset clears the count and controller; the store needs no clearing.
module binary_max_heap_queue
	import bmhq_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	output logic                    done,
	input  logic [1:0]              op,
	input  logic signed [KEY_W-1:0] key_value,
	output logic [1:0]              status,
	output logic signed [KEY_W-1:0] top_removed,
	output logic [CNT_OUT_W-1:0]    removed_count,
	output logic [CNT_OUT_W-1:0]    occupancy
);
	bmhq_cmd_t cmd;
	bmhq_stat_t stat;

	// The controller sequences memory reads, compares and swaps.
	bmhq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.cmd(cmd), .stat(stat)
	);

	// The datapath holds the store, count and working registers.
	bmhq_datapath #(.CAPACITY(CAPACITY)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .op(op),
		.key_value(key_value), .status(status), .top_removed(top_removed),
		.removed_count(removed_count), .occupancy(occupancy)
	);
endmodule
